FILE: rtl/pdts_pkg.sv
`timescale 1ns / 1ps
package pdts_pkg;
    localparam int DefaultSlots = 256;
    localparam int CountW = 32;
    localparam int TempW = 16;
    localparam int SumW = 48;
    localparam logic [CountW-1:0] CountMax = '1;

    typedef struct packed {
        logic                    action;
        logic [7:0]              device_id;
        logic                    valid_req;
        logic signed [TempW-1:0] temperature;
    } t_in_word;

    typedef struct packed {
        logic [CountW-1:0]       processed_count;
        logic [CountW-1:0]       invalid_count;
        logic signed [TempW-1:0] global_min;
        logic signed [TempW-1:0] global_max;
        logic signed [TempW-1:0] global_average;
        logic                    device_present;
        logic [CountW-1:0]       device_samples;
        logic signed [TempW-1:0] device_min;
        logic signed [TempW-1:0] device_max;
        logic signed [SumW-1:0]  device_sum;
        logic signed [TempW-1:0] device_average;
    } t_out_word;

    typedef struct packed {
        logic [CountW-1:0]       count;
        logic signed [SumW-1:0]  sum;
        logic signed [TempW-1:0] mn;
        logic signed [TempW-1:0] mx;
    } t_stats;

    typedef struct packed {
        logic                   start;
        logic signed [SumW-1:0] sum;
        logic [CountW-1:0]      count;
    } t_div_req;

    function automatic t_stats fold(input t_stats s, input logic signed [TempW-1:0] t);
        t_stats r;
        r = s;
        if (s.count == '0) begin
            r.mn = t;
            r.mx = t;
        end else begin
            if (t < s.mn) r.mn = t;
            if (t > s.mx) r.mx = t;
        end
        if (s.count != CountMax) begin
            r.sum = s.sum + SumW'(t);
            r.count = s.count + 1'b1;
        end
        return r;
    endfunction
endpackage

FILE: rtl/pdts_div.sv
`timescale 1ns / 1ps
module pdts_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pdts_pkg::t_div_req                   i_req,
    output logic                                 o_done,
    output logic signed [pdts_pkg::TempW-1:0]    o_quot
);
    import pdts_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0]   r_num, n_num;
    logic [CountW:0]   r_rem, n_rem;
    logic [CountW-1:0] r_den;
    logic              r_neg, r_busy, r_done;
    logic [CntW-1:0]   r_cnt;
    logic [CountW:0]   w_trial;
    logic [SumW-1:0]   w_q;

    assign w_trial = {r_rem[CountW-1:0], r_num[SumW-1]};

    always_comb begin
        n_rem = w_trial;
        n_num = {r_num[SumW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    assign w_q = r_neg ? (~r_num + 1'b1) : r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg  <= i_req.sum[SumW-1];
                r_num  <= i_req.sum[SumW-1] ? (~i_req.sum + 1'b1) : i_req.sum;
                r_den  <= i_req.count;
                r_rem  <= '0;
                r_cnt  <= CntW'(SumW);
                r_busy <= 1'b1;
                if (i_req.count == '0) begin
                    r_num  <= '0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = w_q[TempW-1:0];
endmodule

FILE: rtl/pdts_table.sv
`timescale 1ns / 1ps
module pdts_table #(
    parameter int DeviceSlots = pdts_pkg::DefaultSlots
) (
    input  logic                     i_clk,
    input  logic [$clog2(DeviceSlots)-1:0] i_raddr,
    output pdts_pkg::t_stats         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DeviceSlots)-1:0] i_waddr,
    input  pdts_pkg::t_stats         i_wdata
);
    import pdts_pkg::*;

    t_stats r_mem [DeviceSlots];
    t_stats r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;
endmodule

FILE: rtl/per_device_temperature_stats_core.sv
`timescale 1ns / 1ps
// This block keeps running temperature statistics, globally and per device.
// Each input word either records a sample or queries a device, and each
// word yields exactly one output word with the global figures and the
// figures of the addressed device as they stand after the word.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. One word is processed at a time. The device table is read
// at the edge that accepts the word and updated in the next cycle, in which
// one shared serial divider starts to compute the two averages in turn, one
// quotient bit per cycle over 48 bits. After acceptance the word passes
// S_UPDATE, S_DIVG, S_DIVD and S_OUT; the output word is registered in S_OUT
// as the block returns to S_IDLE. A zero count skips its division. After reset
// the block clears the device table, one entry per cycle, before it accepts
// its first word. A stalled output word holds, and the next word can be taken
// meanwhile. Its result waits until the output word has been taken, and the
// input stays stalled until then.
module per_device_temperature_stats_core #(
    parameter int DEVICE_SLOTS = pdts_pkg::DefaultSlots
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pdts_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pdts_pkg::t_out_word o_out_word
);
    import pdts_pkg::*;

    localparam int AddrW = $clog2(DEVICE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_UPDATE, S_DIVG, S_DIVD, S_OUT
    } t_state;

    t_state r_state;
    logic [AddrW:0]  r_clr;
    t_in_word        r_in;
    t_stats          r_glob;
    logic [CountW-1:0] r_invalid;
    t_stats          r_dev;
    logic            r_in_tab;
    t_out_word       r_out;
    logic            r_out_valid;
    logic signed [TempW-1:0] r_gavg;
    logic signed [TempW-1:0] r_davg;

    logic            w_in_tab;
    logic [AddrW-1:0] w_raddr;
    t_stats          w_rd, w_new;
    t_stats          w_glob;
    logic            w_we;
    logic [AddrW-1:0] w_waddr;
    t_stats          w_wdata;
    t_div_req        w_dreq;
    logic            w_ddone;
    logic signed [TempW-1:0] w_quot;
    logic            w_sample;

    assign w_in_tab = 32'(i_in_word.device_id) < DEVICE_SLOTS;
    assign w_raddr = AddrW'(i_in_word.device_id);
    assign w_sample = !r_in.action && r_in.valid_req;
    assign w_new = (w_sample && r_in_tab) ? fold(w_rd, r_in.temperature) : w_rd;
    assign w_glob = w_sample ? fold(r_glob, r_in.temperature) : r_glob;

    always_comb begin
        w_we = 1'b0;
        w_waddr = AddrW'(r_in.device_id);
        w_wdata = w_new;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_waddr = r_clr[AddrW-1:0];
            w_wdata = '0;
        end else if (r_state == S_UPDATE && w_sample && r_in_tab) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        w_dreq = '0;
        if (r_state == S_UPDATE) begin
            w_dreq.start = 1'b1;
            w_dreq.sum = w_glob.sum;
            w_dreq.count = w_glob.count;
        end else if (r_state == S_DIVG && w_ddone) begin
            w_dreq.start = 1'b1;
            w_dreq.sum = r_dev.sum;
            w_dreq.count = r_dev.count;
        end
    end

    pdts_table #(.DeviceSlots(DEVICE_SLOTS)) u_table (
        .i_clk(i_clk), .i_raddr(w_raddr), .o_rdata(w_rd),
        .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata)
    );

    pdts_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
        .o_done(w_ddone), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_glob      <= '0;
            r_invalid   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AddrW+1)'(DEVICE_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in     <= i_in_word;
                        r_in_tab <= w_in_tab;
                        r_state  <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (!r_in.action && !r_in.valid_req && r_invalid != CountMax)
                        r_invalid <= r_invalid + 1'b1;
                    r_glob  <= w_glob;
                    r_dev   <= r_in_tab ? w_new : '0;
                    r_state <= S_DIVG;
                end
                S_DIVG: begin
                    if (w_ddone) begin
                        r_gavg  <= w_quot;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (w_ddone) begin
                        r_davg  <= w_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out.processed_count <= r_glob.count;
                        r_out.invalid_count   <= r_invalid;
                        r_out.global_min      <= r_glob.mn;
                        r_out.global_max      <= r_glob.mx;
                        r_out.global_average  <= r_gavg;
                        r_out.device_present  <= r_dev.count != '0;
                        r_out.device_samples  <= r_dev.count;
                        r_out.device_min      <= (r_dev.count != '0) ? r_dev.mn : '0;
                        r_out.device_max      <= (r_dev.count != '0) ? r_dev.mx : '0;
                        r_out.device_sum      <= (r_dev.count != '0) ? r_dev.sum : '0;
                        r_out.device_average  <= r_davg;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
endmodule

FILE: rtl/pdts_checker.sv
`timescale 1ns / 1ps
module pdts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pdts_pkg::t_out_word o_out_word
);
    import pdts_pkg::*;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("output word repeated");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.device_present == (o_out_word.device_samples != '0))
        else $error("device presence inconsistent");
endmodule

bind per_device_temperature_stats_core pdts_checker u_pdts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_word(o_out_word)
);
